/* hdl/srms_pkg.sv */
package srms_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int BLOCK_LEN   = 256;

    localparam int SHIFT_AMT = 34 - 2 * SAMPLE_BITS;
    localparam int SH_POS    = (SHIFT_AMT > 0) ? SHIFT_AMT : 0;
    localparam int SH_NEG    = (SHIFT_AMT < 0) ? -SHIFT_AMT : 0;

    localparam int CNT_W  = $clog2(BLOCK_LEN);
    localparam int SQ_W   = 2 * SAMPLE_BITS;
    localparam int LSUM_W = SQ_W + CNT_W;
    localparam int SUM_W  = LSUM_W + 1;
    localparam int MSH_W  = SUM_W + SH_POS;

    localparam int MEAN_DIVISOR = BLOCK_LEN << SH_NEG;

    localparam int Q_W    = 16;
    localparam int SM_W   = 24;
    localparam int MEAN_W = 34;
    localparam int RMS_W  = MEAN_W / 2 + 1;
    localparam int FS_W   = 17;
    localparam int PA_W   = SM_W + Q_W;
    localparam int PB_W   = RMS_W + FS_W;

    localparam int DIV_W  = SM_W + Q_W;
    localparam int DVS_W  = FS_W;
    localparam int DIV_CW = $clog2(DIV_W + 1);

    localparam int IN_W   = ((2 * SAMPLE_BITS + 7) / 8) * 8;
    localparam int OUT_W  = 96;

    localparam int CFG_IW = 8;
    localparam int CFG_DW = 17;

    localparam logic [CFG_IW-1:0] CFG_PLAY_ENABLE       = CFG_IW'(0);
    localparam logic [CFG_IW-1:0] CFG_SMOOTH_COEFF      = CFG_IW'(1);
    localparam logic [CFG_IW-1:0] CFG_RAW_FULL_SCALE    = CFG_IW'(2);
    localparam logic [CFG_IW-1:0] CFG_SMOOTH_FULL_SCALE = CFG_IW'(3);

    localparam logic [15:0]     SMOOTH_COEFF_RST      = 16'd60948;
    localparam logic [FS_W-1:0] RAW_FULL_SCALE_RST    = FS_W'(65536);
    localparam logic [FS_W-1:0] SMOOTH_FULL_SCALE_RST = FS_W'(19661);

    typedef struct packed {
        logic            play_enable;
        logic [15:0]     smooth_coeff;
        logic [FS_W-1:0] raw_full_scale;
        logic [FS_W-1:0] smooth_full_scale;
    } cfg_t;

    typedef struct packed {
        logic [15:0] smooth_meter;
        logic [15:0] raw_meter;
        logic [15:0] smooth_level;
        logic [15:0] raw_level;
    } levels_t;

    typedef struct packed {
        logic load;
        logic acc;
        logic clear;
    } lane_ctl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC,
        ST_MERGE,
        ST_LEVEL,
        ST_EMIT
    } top_state_t;

    typedef enum logic [2:0] {
        LV_IDLE,
        LV_MEAN,
        LV_SQRT,
        LV_MUL,
        LV_SUM,
        LV_RAWM,
        LV_RAWM_WAIT
    } level_state_t;

    function automatic logic [15:0] to_out16(input logic signed [SAMPLE_BITS-1:0] s);
        logic signed [SAMPLE_BITS+15:0] w;
        w = s;
        return w[15:0];
    endfunction

endpackage

/* hdl/srms_lane.sv */
module srms_lane
    import srms_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  lane_ctl_t                     ctl,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    output logic        [LSUM_W-1:0]      acc
);

    logic [SQ_W-1:0]   sq_reg;
    logic [SQ_W-1:0]   sq_next;
    logic [LSUM_W-1:0] acc_reg;
    logic [LSUM_W-1:0] acc_next;

    assign sq_next = SQ_W'(sample * sample);

    always_comb
    begin
        acc_next = acc_reg;
        if (ctl.clear)
        begin
            acc_next = '0;
        end
        else if (ctl.acc)
        begin
            acc_next = acc_reg + LSUM_W'(sq_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            sq_reg <= sq_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

/* hdl/srms_div.sv */
module srms_div
    import srms_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             busy,
    output logic             done,
    output logic [DIV_W-1:0] quotient
);

    logic [DIV_W-1:0]  q_reg;
    logic [DVS_W-1:0]  rem_reg;
    logic [DVS_W-1:0]  dvs_reg;
    logic [DIV_CW-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [DVS_W:0]    rem_shift;
    logic [DVS_W:0]    diff;
    logic              ge;

    assign rem_shift = {rem_reg, q_reg[DIV_W-1]};
    assign ge        = rem_shift >= {1'b0, dvs_reg};
    assign diff      = rem_shift - {1'b0, dvs_reg};

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            q_reg   <= {q_reg[DIV_W-2:0], ge};
            rem_reg <= ge ? diff[DVS_W-1:0] : rem_shift[DVS_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg  <= DIV_CW'(DIV_W);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - DIV_CW'(1);
                if (cnt_reg == DIV_CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

/* hdl/srms_level.sv */
module srms_level
    import srms_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [SUM_W-1:0] square_sum,
    input  cfg_t             cfg,
    output logic             done,
    output levels_t          levels
);

    level_state_t      state_reg;
    level_state_t      state_next;
    logic              smm_reg;
    logic              smm_next;

    logic [SUM_W-1:0]  sum_reg;
    logic [SUM_W-1:0]  sum_next;
    logic [MEAN_W-1:0] x_reg;
    logic [MEAN_W-1:0] x_next;
    logic [MEAN_W:0]   r_reg;
    logic [MEAN_W:0]   r_next;
    logic [MEAN_W-1:0] bit_reg;
    logic [MEAN_W-1:0] bit_next;
    logic [RMS_W-1:0]  rms_reg;
    logic [RMS_W-1:0]  rms_next;
    logic [PA_W-1:0]   pa_reg;
    logic [PA_W-1:0]   pa_next;
    logic [PB_W-1:0]   pb_reg;
    logic [PB_W-1:0]   pb_next;
    logic [SM_W-1:0]   smoothed_reg;
    logic [SM_W-1:0]   smoothed_next;
    logic [15:0]       raw_meter_reg;
    logic [15:0]       raw_meter_next;
    levels_t           levels_reg;
    levels_t           levels_next;

    logic              div_start;
    logic [DIV_W-1:0]  div_dividend;
    logic [DVS_W-1:0]  div_divisor;
    logic              div_busy;
    logic              div_done;
    logic [DIV_W-1:0]  div_quotient;

    logic [MSH_W-1:0]  mean_full;
    logic [MEAN_W:0]   trial;
    logic [FS_W-1:0]   coef_inv;
    logic [PA_W:0]     sm_total;

    function automatic logic [15:0] sat16(input logic [DIV_W-1:0] v);
        return (|v[DIV_W-1:16]) ? 16'hFFFF : v[15:0];
    endfunction

    srms_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // block length is a power of two: the divide reduces to a shift
    assign mean_full = (MSH_W'(sum_reg) << SH_POS) / MSH_W'(MEAN_DIVISOR);
    assign trial     = r_reg + {1'b0, bit_reg};
    assign coef_inv  = FS_W'(65536) - FS_W'(cfg.smooth_coeff);
    assign sm_total  = (PA_W+1)'(pa_reg) + (PA_W+1)'(pb_reg) + (PA_W+1)'(32768);

    always_comb
    begin
        state_next     = state_reg;
        smm_next       = smm_reg;
        sum_next       = sum_reg;
        x_next         = x_reg;
        r_next         = r_reg;
        bit_next       = bit_reg;
        rms_next       = rms_reg;
        pa_next        = pa_reg;
        pb_next        = pb_reg;
        smoothed_next  = smoothed_reg;
        raw_meter_next = raw_meter_reg;
        levels_next    = levels_reg;
        div_start      = 1'b0;
        div_dividend   = '0;
        div_divisor    = DVS_W'(1);
        done           = 1'b0;

        unique case (state_reg)
            LV_IDLE:
            begin
                if (start)
                begin
                    sum_next   = square_sum;
                    state_next = LV_MEAN;
                end
            end
            LV_MEAN:
            begin
                x_next     = mean_full[MEAN_W-1:0];
                r_next     = '0;
                bit_next   = MEAN_W'(1) << (MEAN_W - 2);
                state_next = LV_SQRT;
            end
            LV_SQRT:
            begin
                if ({1'b0, x_reg} >= trial)
                begin
                    x_next = x_reg - trial[MEAN_W-1:0];
                    r_next = (r_reg >> 1) + {1'b0, bit_reg};
                end
                else
                begin
                    r_next = r_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                if (bit_reg[0])
                begin
                    state_next = LV_MUL;
                end
            end
            LV_MUL:
            begin
                rms_next   = r_reg[RMS_W-1:0];
                pa_next    = PA_W'(smoothed_reg) * PA_W'(cfg.smooth_coeff);
                pb_next    = PB_W'(r_reg[RMS_W-1:0]) * PB_W'(coef_inv);
                state_next = LV_SUM;
            end
            LV_SUM:
            begin
                smoothed_next = sm_total[Q_W +: SM_W];
                smm_next      = 1'b0;
                state_next    = LV_RAWM;
            end
            LV_RAWM:
            begin
                div_start = 1'b1;
                if (smm_reg)
                begin
                    div_dividend = DIV_W'({smoothed_reg, 16'h0000});
                    div_divisor  = (cfg.smooth_full_scale != '0) ?
                                   DVS_W'(cfg.smooth_full_scale) : DVS_W'(1);
                end
                else
                begin
                    div_dividend = DIV_W'({rms_reg, 16'h0000});
                    div_divisor  = (cfg.raw_full_scale != '0) ?
                                   DVS_W'(cfg.raw_full_scale) : DVS_W'(1);
                end
                state_next = LV_RAWM_WAIT;
            end
            LV_RAWM_WAIT:
            begin
                if (div_done)
                begin
                    if (smm_reg)
                    begin
                        levels_next.raw_level    = sat16(DIV_W'(rms_reg));
                        levels_next.smooth_level = sat16(DIV_W'(smoothed_reg));
                        levels_next.raw_meter    = raw_meter_reg;
                        levels_next.smooth_meter = sat16(div_quotient);
                        done                     = 1'b1;
                        state_next               = LV_IDLE;
                    end
                    else
                    begin
                        raw_meter_next = sat16(div_quotient);
                        smm_next       = 1'b1;
                        state_next     = LV_RAWM;
                    end
                end
            end
            default:
            begin
                state_next = LV_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= LV_IDLE;
            smm_reg      <= 1'b0;
            smoothed_reg <= '0;
            levels_reg   <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            smm_reg      <= smm_next;
            smoothed_reg <= smoothed_next;
            levels_reg   <= levels_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg       <= sum_next;
        x_reg         <= x_next;
        r_reg         <= r_next;
        bit_reg       <= bit_next;
        rms_reg       <= rms_next;
        pa_reg        <= pa_next;
        pb_reg        <= pb_next;
        raw_meter_reg <= raw_meter_next;
    end

    assign levels = levels_reg;

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("level done held longer than one cycle");

    a_sqrt_bit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == LV_SQRT) |-> $onehot(bit_reg))
        else $error("root step bit not one-hot");

    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider restarted while busy");

endmodule

/* hdl/stereo_rms_level_meter.sv */
// Channel   Signals                                       Direction
// s_axis    tvalid tready tdata[31:0]                     in   sample pairs
// m_axis    tvalid tready tdata[95:0] tuser               out  samples and levels
// cfg       cfg_valid cfg_ready cfg_index cfg_data        in   register writes
//
// A pair inside a block is accepted in ST_IDLE, then accumulated in ST_ACC, which loads the
// output register (ST_EMIT loads it instead while a result waits). The last pair of a block
// also runs the root loop and the shared one-bit-per-cycle divider (two meters).
// Reset clears configuration to defaults, the block sums, the pair count, the smoothed
// level and held levels.
// The output register lets the next pair in while a result waits on m_axis_tready.
module stereo_rms_level_meter
    import srms_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [IN_W-1:0]   s_axis_tdata,   // left_sample, right_sample

    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [OUT_W-1:0]  m_axis_tdata,   // out_left, out_right, raw_level, smooth_level,
                                              // raw_meter, smooth_meter
    output logic              m_axis_tuser,   // level_valid

    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CFG_IW-1:0] cfg_index,
    input  logic [CFG_DW-1:0] cfg_data
);

    top_state_t        state_reg;
    top_state_t        state_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              flag_reg;
    logic              flag_next;
    cfg_t              cfg_reg;

    logic [15:0]       out_l_reg;
    logic [15:0]       out_r_reg;
    logic              m_valid_reg;
    logic [OUT_W-1:0]  m_data_reg;
    logic              m_user_reg;

    lane_ctl_t         lane_ctl;
    logic              load_out;
    logic              out_free;
    logic              level_start;
    logic              level_done;
    levels_t           levels;

    logic signed [SAMPLE_BITS-1:0] left_sample;
    logic signed [SAMPLE_BITS-1:0] right_sample;
    logic [LSUM_W-1:0] acc_l;
    logic [LSUM_W-1:0] acc_r;
    logic [SUM_W-1:0]  merged_sum;

    assign left_sample  = s_axis_tdata[SAMPLE_BITS-1:0];
    assign right_sample = s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
    assign cfg_ready    = 1'b1;
    assign out_free     = !m_valid_reg || m_axis_tready;
    assign merged_sum   = SUM_W'(acc_l) + SUM_W'(acc_r);

    srms_lane u_lane_l (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (lane_ctl),
        .sample (left_sample),
        .acc    (acc_l)
    );

    srms_lane u_lane_r (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (lane_ctl),
        .sample (right_sample),
        .acc    (acc_r)
    );

    srms_level u_level (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (level_start),
        .square_sum (merged_sum),
        .cfg        (cfg_reg),
        .done       (level_done),
        .levels     (levels)
    );

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        flag_next     = flag_reg;
        lane_ctl      = '0;
        load_out      = 1'b0;
        level_start   = 1'b0;
        s_axis_tready = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    lane_ctl.load = 1'b1;
                    state_next    = ST_ACC;
                end
            end
            ST_ACC:
            begin
                lane_ctl.acc = 1'b1;
                if (count_reg == CNT_W'(BLOCK_LEN - 1))
                begin
                    count_next = '0;
                    flag_next  = 1'b1;
                    state_next = ST_MERGE;
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                    flag_next  = 1'b0;
                    if (out_free)
                    begin
                        load_out   = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_MERGE:
            begin
                lane_ctl.clear = 1'b1;
                level_start    = 1'b1;
                state_next     = ST_LEVEL;
            end
            ST_LEVEL:
            begin
                if (level_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            flag_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            flag_reg  <= flag_next;
            if (load_out)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.play_enable       <= 1'b1;
            cfg_reg.smooth_coeff      <= SMOOTH_COEFF_RST;
            cfg_reg.raw_full_scale    <= RAW_FULL_SCALE_RST;
            cfg_reg.smooth_full_scale <= SMOOTH_FULL_SCALE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_PLAY_ENABLE:       cfg_reg.play_enable       <= cfg_data[0];
                CFG_SMOOTH_COEFF:      cfg_reg.smooth_coeff      <= cfg_data[15:0];
                CFG_RAW_FULL_SCALE:    cfg_reg.raw_full_scale    <= cfg_data[FS_W-1:0];
                CFG_SMOOTH_FULL_SCALE: cfg_reg.smooth_full_scale <= cfg_data[FS_W-1:0];
                default:               ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            out_l_reg <= cfg_reg.play_enable ? to_out16(left_sample) : 16'h0000;
            out_r_reg <= cfg_reg.play_enable ? to_out16(right_sample) : 16'h0000;
        end
        if (load_out)
        begin
            m_data_reg <= {levels, out_r_reg, out_l_reg};
            m_user_reg <= flag_next;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(BLOCK_LEN - 1))
        else $error("pair count beyond block length");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LEVEL) |-> !s_axis_tready)
        else $error("pair accepted during block level computation");

endmodule

/* tb/sv/tb_top.sv */
module tb_top;
    import srms_pkg::*;

    localparam int          HOLD_CYCLES  = 300;
    localparam int          DRAIN_CYCLES = 20;
    localparam int          END_CYCLES   = 200;
    localparam int          PHASES       = 6;
    localparam int          PHASE_PAIRS  = 128;
    localparam logic [CFG_IW-1:0] CFG_IDX_UNUSED = CFG_IW'(4);
    localparam logic [CFG_IW-1:0] CFG_IDX_TOP    = '1;

    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_PAIR,
        ROW_LIT
    } row_kind_t;

    typedef enum int {
        CLS_FULL,
        CLS_PEAK,
        CLS_QUIET,
        CLS_SILENT,
        CLS_MONO
    } sample_class_t;

    typedef struct packed {
        row_kind_t         kind;
        logic [CFG_IW-1:0] idx;
        logic [CFG_DW-1:0] val;
        logic [15:0]       l;
        logic [15:0]       r;
        logic [15:0]       exp_l;
        logic [15:0]       exp_r;
    } dir_row_t;

    typedef struct packed {
        logic [15:0] out_l;
        logic [15:0] out_r;
        logic        lvl_valid;
        logic [15:0] raw_lvl;
        logic [15:0] sm_lvl;
        logic [15:0] raw_m;
        logic [15:0] sm_m;
    } pair_result_t;

    localparam int DIR_ROWS = 19;

    // literal rows all fall inside the first block, so levels are still zero
    dir_row_t dir_rows [0:DIR_ROWS-1] = '{
        '{ROW_LIT,  '0, '0, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
        '{ROW_LIT,  '0, '0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF},
        '{ROW_LIT,  '0, '0, 16'h8000, 16'h8000, 16'h8000, 16'h8000},
        '{ROW_LIT,  '0, '0, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000},
        '{ROW_LIT,  '0, '0, 16'hFFFF, 16'h0001, 16'hFFFF, 16'h0001},
        '{ROW_LIT,  '0, '0, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA},
        '{ROW_PAIR, '0, '0, 16'h04D2, 16'h04D2, 16'h0000, 16'h0000},
        '{ROW_PAIR, '0, '0, 16'h1234, 16'hFEDC, 16'h0000, 16'h0000},
        '{ROW_CFG,  CFG_PLAY_ENABLE, 17'h00000, 16'h0, 16'h0, 16'h0, 16'h0},
        '{ROW_LIT,  '0, '0, 16'h7FFF, 16'h8000, 16'h0000, 16'h0000},
        '{ROW_LIT,  '0, '0, 16'hFFFF, 16'h3039, 16'h0000, 16'h0000},
        '{ROW_CFG,  CFG_PLAY_ENABLE, 17'h1FFFE, 16'h0, 16'h0, 16'h0, 16'h0},
        '{ROW_LIT,  '0, '0, 16'h0064, 16'hFF9C, 16'h0000, 16'h0000},
        '{ROW_CFG,  CFG_IDX_UNUSED, 17'h1FFFF, 16'h0, 16'h0, 16'h0, 16'h0},
        '{ROW_CFG,  CFG_IDX_TOP, 17'h00001, 16'h0, 16'h0, 16'h0, 16'h0},
        '{ROW_LIT,  '0, '0, 16'h0007, 16'h0007, 16'h0000, 16'h0000},
        '{ROW_CFG,  CFG_PLAY_ENABLE, 17'h00001, 16'h0, 16'h0, 16'h0, 16'h0},
        '{ROW_PAIR, '0, '0, 16'h8000, 16'h7FFF, 16'h0000, 16'h0000},
        '{ROW_PAIR, '0, '0, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000}
    };

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [IN_W-1:0]   s_axis_tdata = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [OUT_W-1:0]  m_axis_tdata;
    logic              m_axis_tuser;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [CFG_IW-1:0] cfg_index = '0;
    logic [CFG_DW-1:0] cfg_data = '0;

    logic              lit_flag = 1'b0;
    logic [31:0]       lit_out = '0;

    int                src_idle_pct = 6;
    int                sink_idle_pct = 73;
    int                hold_asks = 0;
    int                hold_seen = 0;
    int                hold_left = 0;
    int                fail_count = 0;

    cfg_t              meter_cfg = '{1'b1, SMOOTH_COEFF_RST, RAW_FULL_SCALE_RST,
                                     SMOOTH_FULL_SCALE_RST};
    logic [63:0]       sq_sum = '0;
    int                pair_cnt = 0;
    logic [23:0]       smoothed = '0;
    levels_t           held_lv = '0;
    pair_result_t      pending_results [$];

    stereo_rms_level_meter uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #6 clk = ~clk;

    function automatic logic [15:0] clip16(input logic [63:0] v);
        return (v > 64'd65535) ? 16'hFFFF : v[15:0];
    endfunction

    function automatic logic [15:0] meter_value(input logic [63:0] level,
                                                input logic [FS_W-1:0] fs);
        logic [63:0] div;
        div = (fs == '0) ? 64'd1 : 64'(fs);
        return clip16((level << 16) / div);
    endfunction

    function automatic pair_result_t predict_pair(input logic [15:0] l, input logic [15:0] r);
        pair_result_t res;
        longint       sl;
        longint       sr;
        logic [63:0]  mean_sq;
        logic [63:0]  root;
        logic [63:0]  trial;
        logic [63:0]  sm_next;
        sl = longint'($signed(l));
        sr = longint'($signed(r));
        sq_sum = sq_sum + 64'(sl * sl) + 64'(sr * sr);
        res.out_l = meter_cfg.play_enable ? l : 16'h0000;
        res.out_r = meter_cfg.play_enable ? r : 16'h0000;
        res.lvl_valid = 1'b0;
        if (pair_cnt >= BLOCK_LEN - 1)
        begin
            mean_sq = (sq_sum << SH_POS) / 64'(MEAN_DIVISOR);
            // largest root whose square does not exceed the mean square
            root = '0;
            for (int b = 17; b >= 0; b--)
            begin
                trial = root | (64'd1 << b);
                if (trial * trial <= mean_sq)
                    root = trial;
            end
            sm_next = (64'(smoothed) * 64'(meter_cfg.smooth_coeff)
                       + root * (64'd65536 - 64'(meter_cfg.smooth_coeff)) + 64'd32768) >> 16;
            smoothed = sm_next[23:0];
            held_lv.raw_level    = clip16(root);
            held_lv.smooth_level = clip16(64'(smoothed));
            held_lv.raw_meter    = meter_value(root, meter_cfg.raw_full_scale);
            held_lv.smooth_meter = meter_value(64'(smoothed), meter_cfg.smooth_full_scale);
            sq_sum = '0;
            pair_cnt = 0;
            res.lvl_valid = 1'b1;
        end
        else
            pair_cnt++;
        res.raw_lvl = held_lv.raw_level;
        res.sm_lvl  = held_lv.smooth_level;
        res.raw_m   = held_lv.raw_meter;
        res.sm_m    = held_lv.smooth_meter;
        return res;
    endfunction

    function automatic void compare_field(input string name, input logic [15:0] exp_v,
                                          input logic [15:0] act_v);
        if (act_v !== exp_v)
        begin
            fail_count++;
            if (fail_count <= 10)
                $display("mismatch %s: expected %h, got %h", name, exp_v, act_v);
        end
    endfunction

    function automatic logic [15:0] pick_sample(input sample_class_t k);
        logic [15:0] q;
        if ($urandom_range(19) == 0)
            return 16'($urandom);
        case (k)
            CLS_PEAK:
                return $urandom_range(1) ? 16'h7FFF : 16'h8000;
            CLS_QUIET:
            begin
                q = 16'($urandom_range(511));
                return q - 16'd256;
            end
            CLS_SILENT:
                return 16'h0000;
            default:
                return 16'($urandom);
        endcase
    endfunction

    always @(posedge clk)
    begin
        pair_result_t exp_r;
        pair_result_t pred;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pending_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected transfer: %h user %b", m_axis_tdata, m_axis_tuser);
                end
                else
                begin
                    exp_r = pending_results.pop_front();
                    compare_field("out_left",     exp_r.out_l,   m_axis_tdata[15:0]);
                    compare_field("out_right",    exp_r.out_r,   m_axis_tdata[31:16]);
                    compare_field("level_valid",  {15'b0, exp_r.lvl_valid},
                                  {15'b0, m_axis_tuser});
                    compare_field("raw_level",    exp_r.raw_lvl, m_axis_tdata[47:32]);
                    compare_field("smooth_level", exp_r.sm_lvl,  m_axis_tdata[63:48]);
                    compare_field("raw_meter",    exp_r.raw_m,   m_axis_tdata[79:64]);
                    compare_field("smooth_meter", exp_r.sm_m,    m_axis_tdata[95:80]);
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_PLAY_ENABLE:       meter_cfg.play_enable = cfg_data[0];
                    CFG_SMOOTH_COEFF:      meter_cfg.smooth_coeff = cfg_data[15:0];
                    CFG_RAW_FULL_SCALE:    meter_cfg.raw_full_scale = cfg_data[FS_W-1:0];
                    CFG_SMOOTH_FULL_SCALE: meter_cfg.smooth_full_scale = cfg_data[FS_W-1:0];
                    default:;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                pred = predict_pair(s_axis_tdata[15:0], s_axis_tdata[31:16]);
                if (lit_flag)
                    pred = '{lit_out[15:0], lit_out[31:16], 1'b0, 16'h0, 16'h0, 16'h0, 16'h0};
                pending_results.push_back(pred);
            end
        end
    end

    // output side: random idling plus a long hold-off on request
    always @(negedge clk)
    begin
        if (hold_seen != hold_asks)
        begin
            hold_seen <= hold_asks;
            hold_left <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    task automatic send_pair(input logic [15:0] l, input logic [15:0] r, input logic lit,
                             input logic [31:0] lit_val);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {r, l};
        lit_flag      <= lit;
        lit_out       <= lit_val;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic drain();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        #(12 * 400000);
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        logic [CFG_DW-1:0] pe;
        logic [CFG_DW-1:0] co;
        logic [CFG_DW-1:0] rf;
        logic [CFG_DW-1:0] sf;
        logic [15:0]       l;
        logic [15:0]       r;
        sample_class_t     blk_class;
        int                pairs_sent;

        pairs_sent = 0;
        blk_class = CLS_PEAK;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int k = 0; k < DIR_ROWS; k++)
        begin
            if (dir_rows[k].kind == ROW_CFG)
            begin
                drain();
                write_reg(dir_rows[k].idx, dir_rows[k].val);
            end
            else
            begin
                send_pair(dir_rows[k].l, dir_rows[k].r, dir_rows[k].kind == ROW_LIT,
                          {dir_rows[k].exp_r, dir_rows[k].exp_l});
                pairs_sent++;
            end
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain();
            case (ph)
                0:
                begin
                    pe = '0;
                    co = 17'($urandom_range(65535));
                    rf = RAW_FULL_SCALE_RST;
                    sf = SMOOTH_FULL_SCALE_RST;
                end
                1:
                begin
                    pe = 17'd1;
                    co = '0;
                    rf = '0;
                    sf = 17'd1;
                end
                2:
                begin
                    pe = 17'($urandom_range(1));
                    co = '1;
                    rf = '1;
                    sf = 17'h10000;
                end
                3:
                begin
                    pe = '1;
                    co = '1;
                    rf = '1;
                    sf = 17'h10000;
                end
                4:
                begin
                    pe = 17'($urandom);
                    co = 17'($urandom);
                    rf = 17'($urandom_range(131071, 1));
                    sf = 17'($urandom_range(131071));
                end
                default:
                begin
                    pe = 17'd1;
                    co = 17'(SMOOTH_COEFF_RST);
                    rf = RAW_FULL_SCALE_RST;
                    sf = SMOOTH_FULL_SCALE_RST;
                end
            endcase
            write_reg(CFG_PLAY_ENABLE, pe);
            write_reg(CFG_SMOOTH_COEFF, co);
            write_reg(CFG_RAW_FULL_SCALE, rf);
            write_reg(CFG_SMOOTH_FULL_SCALE, sf);

            case (ph / 2)
                0:
                begin
                    src_idle_pct = 6;
                    sink_idle_pct = 73;
                end
                1:
                begin
                    src_idle_pct = 73;
                    sink_idle_pct = 6;
                end
                default:
                begin
                    src_idle_pct = 0;
                    sink_idle_pct = 0;
                end
            endcase

            for (int i = 0; i < PHASE_PAIRS; i++)
            begin
                if (ph == 2 && i == 50)
                    drain();
                if (ph == 4 && i == 40)
                    hold_asks++;
                if (pairs_sent % BLOCK_LEN == 0)
                    blk_class = sample_class_t'($urandom_range(CLS_MONO));
                l = pick_sample(blk_class);
                r = (blk_class == CLS_MONO) ? l : pick_sample(blk_class);
                send_pair(l, r, 1'b0, '0);
                pairs_sent++;
            end
        end

        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (END_CYCLES) @(negedge clk);
        if (fail_count == 0 && pending_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

/* filelist.f */
hdl/srms_pkg.sv
hdl/srms_lane.sv
hdl/srms_div.sv
hdl/srms_level.sv
hdl/stereo_rms_level_meter.sv
tb/sv/tb_top.sv
